>>> rtl/uart_fifo_xon_xoff_flow_defines.svh
// Assertion macros for the checker of the serial port core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UART_FIFO_XON_XOFF_FLOW_DEFINES_SVH
`define UART_FIFO_XON_XOFF_FLOW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UFXF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial port check failed");

// Next-cycle implication, disabled during reset.
`define UFXF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial port check failed");

`endif

>>> rtl/ufxf_pkg.sv
// Shared types and constants of the buffered serial port core.
// No dependencies; every other file but the defines header refers to this package by scoped names.
package ufxf_pkg;

    localparam int BYTE_W = 8;

    // Event kinds
    localparam logic [2:0] KIND_LINE_RX  = 3'd0;
    localparam logic [2:0] KIND_READ     = 3'd1;
    localparam logic [2:0] KIND_WRITE    = 3'd2;
    localparam logic [2:0] KIND_TX_READY = 3'd3;
    localparam logic [2:0] KIND_SET_FLOW = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_WR_FULL    = 2'd1;
    localparam logic [1:0] STAT_RX_DROPPED = 2'd2;
    localparam logic [1:0] STAT_RD_EMPTY   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLOW_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_FLOW_MARGIN  = 2'd1;
    localparam logic [1:0] CFG_CR_BEFORE_LF = 2'd2;

    // Character codes
    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NONE = 8'h00;

    localparam logic [4:0] MARGIN_RESET = 5'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RX_READ,
        ST_TX_READ,
        ST_LF_WRITE
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } in_t;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [1:0] status;
        logic [5:0] rx_fill;
        logic [5:0] tx_fill;
        logic       flow_on;
    } out_t;

endpackage

>>> rtl/ufxf_ram.sv
// Byte-wide ring buffer storage: one write port, one read port, registered read.
// Uses ufxf_pkg for the byte width.
module ufxf_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [ufxf_pkg::BYTE_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [ufxf_pkg::BYTE_W-1:0]  rd_data
);

    logic [ufxf_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [ufxf_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/uart_fifo_xon_xoff_flow.sv
// Top level of the buffered serial port core with XON/XOFF flow control.
// Depends on ufxf_pkg and instantiates ufxf_ram for both ring buffers.

// Each transaction is one event: a byte from the line, a host read, a host write,
// a transmitter-ready tick or a host flow override. Both ring buffers live in
// single-port-read synchronous RAMs, so an event that pops a byte (a read of a
// non-empty receive buffer, or a transmitter tick that sends buffered data) passes
// through a second state for the registered read data, as does a line feed written
// with CR insertion on, which needs two writes through the one write port. All
// other events complete in the idle state. A result register plus one skid entry
// let the next transaction be taken while a result waits; apart from those second
// states, input stalls only when both are occupied. Each buffer holds depth minus
// one bytes; fill outputs are the fill modulo 64.
module uart_fifo_xon_xoff_flow #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ufxf_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ufxf_pkg::out_t    out_data,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_FW = RX_AW + 6;
    localparam logic [RX_AW-1:0] RX_LAST  = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST  = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW:0]   RX_DEPTH_W = (RX_AW + 1)'(RX_DEPTH);
    localparam logic [TX_AW:0]   TX_DEPTH_W = (TX_AW + 1)'(TX_DEPTH);
    localparam logic [RX_FW-1:0] RX_DEPTH_F = RX_FW'(RX_DEPTH);

    ufxf_pkg::state_t state_reg, state_next;

    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic             flow_state_reg, flow_state_next;
    logic [7:0]       pending_reg, pending_next;
    logic             flow_enable_reg;
    logic [4:0]       flow_margin_reg;
    logic             cr_lf_reg;

    logic             out_valid_reg, out_valid_next;
    ufxf_pkg::out_t   out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    ufxf_pkg::out_t   skid_data_reg, skid_data_next;

    // RAM ports
    logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [RX_AW-1:0] rx_rd_addr;
    logic [TX_AW-1:0] tx_wr_addr, tx_rd_addr;
    logic [7:0]       tx_wr_data, rx_rd_data, tx_rd_data;

    logic             in_fire, done;
    ufxf_pkg::out_t   res_base, res;

    logic [RX_AW-1:0] rx_cnt, rx_cnt_next;
    logic [TX_AW-1:0] tx_cnt, tx_cnt_next;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc, tx_free;
    logic [RX_AW-1:0] rx_fill_new;
    logic [RX_AW:0]   rx_diff, rx_diff_next;
    logic [TX_AW:0]   tx_diff, tx_diff_next;
    logic [RX_AW+5:0] rx_fill_ext;
    logic [TX_AW+5:0] tx_fill_ext;
    logic             add_cr;

    ufxf_ram #(.DEPTH(RX_DEPTH), .AW(RX_AW)) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_head_reg),
        .wr_data (in_data.data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    ufxf_ram #(.DEPTH(TX_DEPTH), .AW(TX_AW)) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    assign in_ready  = (state_reg == ufxf_pkg::ST_IDLE) && !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Fill counts of the current pointers
    always_comb
    begin
        rx_diff = {1'b0, rx_head_reg} - {1'b0, rx_tail_reg};
        if (rx_head_reg < rx_tail_reg)
        begin
            rx_diff = rx_diff + RX_DEPTH_W;
        end
        rx_cnt = rx_diff[RX_AW-1:0];
        tx_diff = {1'b0, tx_head_reg} - {1'b0, tx_tail_reg};
        if (tx_head_reg < tx_tail_reg)
        begin
            tx_diff = tx_diff + TX_DEPTH_W;
        end
        tx_cnt = tx_diff[TX_AW-1:0];
        rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
        rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
        tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
        tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;
        tx_free = TX_LAST - tx_cnt;
    end

    // Event decode: pointer updates, RAM accesses, flow control
    always_comb
    begin
        state_next      = state_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        flow_state_next = flow_state_reg;
        pending_next    = pending_reg;
        rx_wr_en        = 1'b0;
        rx_rd_en        = 1'b0;
        rx_rd_addr      = rx_tail_reg;
        tx_wr_en        = 1'b0;
        tx_wr_addr      = tx_head_reg;
        tx_wr_data      = in_data.data;
        tx_rd_en        = 1'b0;
        tx_rd_addr      = tx_tail_reg;
        rx_fill_new     = rx_cnt;
        add_cr          = 1'b0;
        done            = 1'b0;
        res_base        = '0;

        case (state_reg)
            ufxf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    done = 1'b1;
                    case (in_data.kind)
                        ufxf_pkg::KIND_LINE_RX:
                        begin
                            if (rx_cnt == RX_LAST)
                            begin
                                res_base.status = ufxf_pkg::STAT_RX_DROPPED;
                            end
                            else
                            begin
                                rx_wr_en     = 1'b1;
                                rx_head_next = rx_head_inc;
                                rx_fill_new  = rx_cnt + 1'b1;
                            end
                            if (flow_enable_reg && flow_state_reg &&
                                ({6'b0, rx_fill_new} + RX_FW'(flow_margin_reg) >= RX_DEPTH_F))
                            begin
                                pending_next    = ufxf_pkg::CH_XOFF;
                                flow_state_next = 1'b0;
                            end
                        end
                        ufxf_pkg::KIND_READ:
                        begin
                            if (rx_cnt == '0)
                            begin
                                res_base.status = ufxf_pkg::STAT_RD_EMPTY;
                            end
                            else
                            begin
                                rx_rd_en     = 1'b1;
                                rx_tail_next = rx_tail_inc;
                                rx_fill_new  = rx_cnt - 1'b1;
                                done         = 1'b0;
                                state_next   = ufxf_pkg::ST_RX_READ;
                            end
                            if (flow_enable_reg && !flow_state_reg &&
                                ({6'b0, rx_fill_new} <= RX_FW'(flow_margin_reg)))
                            begin
                                pending_next    = ufxf_pkg::CH_XON;
                                flow_state_next = 1'b1;
                            end
                        end
                        ufxf_pkg::KIND_WRITE:
                        begin
                            add_cr = cr_lf_reg && (in_data.data == ufxf_pkg::CH_LF);
                            if (tx_free == '0 || (add_cr && tx_free == TX_AW'(1)))
                            begin
                                res_base.status = ufxf_pkg::STAT_WR_FULL;
                            end
                            else
                            begin
                                tx_wr_en     = 1'b1;
                                tx_head_next = tx_head_inc;
                                if (add_cr)
                                begin
                                    // CR now, the LF itself in the next cycle
                                    tx_wr_data = ufxf_pkg::CH_CR;
                                    done       = 1'b0;
                                    state_next = ufxf_pkg::ST_LF_WRITE;
                                end
                            end
                        end
                        ufxf_pkg::KIND_TX_READY:
                        begin
                            if (pending_reg != ufxf_pkg::CH_NONE)
                            begin
                                res_base.line_valid = 1'b1;
                                res_base.line_byte  = pending_reg;
                                pending_next        = ufxf_pkg::CH_NONE;
                            end
                            else if (tx_cnt != '0)
                            begin
                                tx_rd_en     = 1'b1;
                                tx_tail_next = tx_tail_inc;
                                done         = 1'b0;
                                state_next   = ufxf_pkg::ST_TX_READ;
                            end
                        end
                        ufxf_pkg::KIND_SET_FLOW:
                        begin
                            if (flow_enable_reg && (in_data.data[0] != flow_state_reg))
                            begin
                                pending_next    = in_data.data[0] ? ufxf_pkg::CH_XON
                                                                  : ufxf_pkg::CH_XOFF;
                                flow_state_next = in_data.data[0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ufxf_pkg::ST_RX_READ:
            begin
                done                = 1'b1;
                res_base.read_valid = 1'b1;
                res_base.read_byte  = rx_rd_data;
                state_next          = ufxf_pkg::ST_IDLE;
            end
            ufxf_pkg::ST_TX_READ:
            begin
                done                = 1'b1;
                res_base.line_valid = 1'b1;
                res_base.line_byte  = tx_rd_data;
                state_next          = ufxf_pkg::ST_IDLE;
            end
            ufxf_pkg::ST_LF_WRITE:
            begin
                done         = 1'b1;
                tx_wr_en     = 1'b1;
                tx_wr_data   = ufxf_pkg::CH_LF;
                tx_head_next = tx_head_inc;
                state_next   = ufxf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ufxf_pkg::ST_IDLE;
            end
        endcase
    end

    // Fill counts after the event, then the complete result
    always_comb
    begin
        rx_diff_next = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
        if (rx_head_next < rx_tail_next)
        begin
            rx_diff_next = rx_diff_next + RX_DEPTH_W;
        end
        rx_cnt_next = rx_diff_next[RX_AW-1:0];
        tx_diff_next = {1'b0, tx_head_next} - {1'b0, tx_tail_next};
        if (tx_head_next < tx_tail_next)
        begin
            tx_diff_next = tx_diff_next + TX_DEPTH_W;
        end
        tx_cnt_next = tx_diff_next[TX_AW-1:0];
        rx_fill_ext = {6'b0, rx_cnt_next};
        tx_fill_ext = {6'b0, tx_cnt_next};
        res         = res_base;
        res.rx_fill = rx_fill_ext[5:0];
        res.tx_fill = tx_fill_ext[5:0];
        res.flow_on = flow_state_next;
    end

    // Result register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = done;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = done;
                out_data_next  = res;
            end
        end
        else if (done)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ufxf_pkg::ST_IDLE;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            tx_head_reg     <= '0;
            tx_tail_reg     <= '0;
            flow_state_reg  <= 1'b1;
            pending_reg     <= ufxf_pkg::CH_NONE;
            flow_enable_reg <= 1'b1;
            flow_margin_reg <= ufxf_pkg::MARGIN_RESET;
            cr_lf_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rx_head_reg    <= rx_head_next;
            rx_tail_reg    <= rx_tail_next;
            tx_head_reg    <= tx_head_next;
            tx_tail_reg    <= tx_tail_next;
            flow_state_reg <= flow_state_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    ufxf_pkg::CFG_FLOW_ENABLE:  flow_enable_reg <= cfg_data[0];
                    ufxf_pkg::CFG_FLOW_MARGIN:  flow_margin_reg <= cfg_data;
                    ufxf_pkg::CFG_CR_BEFORE_LF: cr_lf_reg       <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/ufxf_checker.sv
// Port-level checks for the serial port core, bound to its top level.
// Depends on ufxf_pkg and the assertion macros in the defines header.
`include "uart_fifo_xon_xoff_flow_defines.svh"

module ufxf_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input ufxf_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input ufxf_pkg::out_t out_data
);

    // A stalled input transaction holds its payload
    `UFXF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

    // A stalled result holds its value
    `UFXF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Byte fields are zero unless flagged valid
    `UFXF_ASSERT_NOW(a_zero_bytes, out_valid, (out_data.line_valid || out_data.line_byte == 8'h00) && (out_data.read_valid || out_data.read_byte == 8'h00))

    // A successful read reports ok and sends nothing to the line
    `UFXF_ASSERT_NOW(a_read_ok, out_valid && out_data.read_valid, out_data.status == ufxf_pkg::STAT_OK && !out_data.line_valid)

    // Line bytes never coincide with an error status
    `UFXF_ASSERT_NOW(a_line_ok, out_valid && out_data.line_valid, out_data.status == ufxf_pkg::STAT_OK)

endmodule

bind uart_fifo_xon_xoff_flow ufxf_checker u_ufxf_checker (.*);

>>> bench/tb_top.sv
// Testbench for the buffered serial port core with XON/XOFF flow control.
// Needs ufxf_pkg and uart_fifo_xon_xoff_flow; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = 64;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 120;

    typedef enum int {
        MIX_FILL_RX,
        MIX_DRAIN_RX,
        MIX_FILL_TX,
        MIX_DRAIN_TX,
        MIX_ANY
    } traffic_t;

    class serial_port_scoreboard;
        logic [7:0] rx_mem [DEPTH];
        logic [7:0] tx_mem [DEPTH];
        logic [5:0] rx_wr, rx_rd, tx_wr, tx_rd;
        logic       flow_state;
        logic [7:0] ctrl_pending;
        logic       flow_en;
        logic [4:0] margin;
        logic       cr_lf;
        ufxf_pkg::out_t awaited_results [$];
        int         mismatches;

        function new();
            rx_wr = '0;
            rx_rd = '0;
            tx_wr = '0;
            tx_rd = '0;
            flow_state = 1'b1;
            ctrl_pending = ufxf_pkg::CH_NONE;
            flow_en = 1'b1;
            margin = ufxf_pkg::MARGIN_RESET;
            cr_lf = 1'b0;
            mismatches = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [4:0] value);
            case (index)
                ufxf_pkg::CFG_FLOW_ENABLE:  flow_en = value[0];
                ufxf_pkg::CFG_FLOW_MARGIN:  margin = value;
                ufxf_pkg::CFG_CR_BEFORE_LF: cr_lf = value[0];
                default: ;
            endcase
        endfunction

        function int rx_used();
            logic [5:0] d;
            d = rx_wr - rx_rd;
            return int'(d);
        endfunction

        function int tx_used();
            logic [5:0] d;
            d = tx_wr - tx_rd;
            return int'(d);
        endfunction

        function void push_tx(logic [7:0] b);
            tx_mem[tx_wr] = b;
            tx_wr++;
        endfunction

        // Advance the shadow state by one transaction and queue its result.
        function void note_event(ufxf_pkg::in_t ev);
            ufxf_pkg::out_t r;
            logic add_cr;
            r = '0;
            r.status = ufxf_pkg::STAT_OK;
            case (ev.kind)
                ufxf_pkg::KIND_LINE_RX: begin
                    if (rx_used() >= DEPTH - 1)
                        r.status = ufxf_pkg::STAT_RX_DROPPED;
                    else begin
                        rx_mem[rx_wr] = ev.data;
                        rx_wr++;
                    end
                    if (flow_en && flow_state && rx_used() + int'(margin) >= DEPTH) begin
                        ctrl_pending = ufxf_pkg::CH_XOFF;
                        flow_state = 1'b0;
                    end
                end
                ufxf_pkg::KIND_READ: begin
                    if (rx_used() == 0)
                        r.status = ufxf_pkg::STAT_RD_EMPTY;
                    else begin
                        r.read_valid = 1'b1;
                        r.read_byte = rx_mem[rx_rd];
                        rx_rd++;
                    end
                    if (flow_en && !flow_state && rx_used() <= int'(margin)) begin
                        ctrl_pending = ufxf_pkg::CH_XON;
                        flow_state = 1'b1;
                    end
                end
                ufxf_pkg::KIND_WRITE: begin
                    add_cr = cr_lf && ev.data == ufxf_pkg::CH_LF;
                    if (DEPTH - 1 - tx_used() < (add_cr ? 2 : 1))
                        r.status = ufxf_pkg::STAT_WR_FULL;
                    else begin
                        if (add_cr)
                            push_tx(ufxf_pkg::CH_CR);
                        push_tx(ev.data);
                    end
                end
                ufxf_pkg::KIND_TX_READY: begin
                    if (ctrl_pending != ufxf_pkg::CH_NONE) begin
                        r.line_valid = 1'b1;
                        r.line_byte = ctrl_pending;
                        ctrl_pending = ufxf_pkg::CH_NONE;
                    end
                    else if (tx_used() != 0) begin
                        r.line_valid = 1'b1;
                        r.line_byte = tx_mem[tx_rd];
                        tx_rd++;
                    end
                end
                ufxf_pkg::KIND_SET_FLOW: begin
                    if (flow_en && ev.data[0] != flow_state) begin
                        ctrl_pending = ev.data[0] ? ufxf_pkg::CH_XON : ufxf_pkg::CH_XOFF;
                        flow_state = ev.data[0];
                    end
                end
                default: ;
            endcase
            r.rx_fill = rx_wr - rx_rd;
            r.tx_fill = tx_wr - tx_rd;
            r.flow_on = flow_state;
            awaited_results.push_back(r);
        endfunction

        function void report(string what, ufxf_pkg::out_t want, ufxf_pkg::out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: expected lv=%0d lb=%h rv=%0d rb=%h st=%0d rx=%0d tx=%0d fl=%0d,",
                          " got lv=%0d lb=%h rv=%0d rb=%h st=%0d rx=%0d tx=%0d fl=%0d"},
                         what, want.line_valid, want.line_byte, want.read_valid,
                         want.read_byte, want.status, want.rx_fill, want.tx_fill,
                         want.flow_on, got.line_valid, got.line_byte, got.read_valid,
                         got.read_byte, got.status, got.rx_fill, got.tx_fill, got.flow_on);
        endfunction

        function void check_result(ufxf_pkg::out_t got);
            ufxf_pkg::out_t want;
            if (awaited_results.size() == 0) begin
                report("result with none awaited", '0, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.line_valid !== want.line_valid || got.line_byte !== want.line_byte ||
                got.read_valid !== want.read_valid || got.read_byte !== want.read_byte ||
                got.status !== want.status || got.rx_fill !== want.rx_fill ||
                got.tx_fill !== want.tx_fill || got.flow_on !== want.flow_on)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    ufxf_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    ufxf_pkg::out_t out_data;
    logic           cfg_write;
    logic [1:0]     cfg_index;
    logic [4:0]     cfg_data;

    bit idle_on;
    bit hold_request;

    serial_port_scoreboard sb = new();

    uart_fifo_xon_xoff_flow u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_event(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_event(input logic [2:0] kind, input logic [7:0] data);
        in_valid <= 1'b1;
        in_data <= '{kind: kind, data: data};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic sender_pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Advance the clock first so the scoreboard has noted the last accepted transaction
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input bit en, input logic [4:0] m, input bit cr);
        cfg_write <= 1'b1;
        cfg_index <= ufxf_pkg::CFG_FLOW_ENABLE;
        cfg_data <= {4'd0, en};
        @(posedge clk);
        cfg_index <= ufxf_pkg::CFG_FLOW_MARGIN;
        cfg_data <= m;
        @(posedge clk);
        cfg_index <= ufxf_pkg::CFG_CR_BEFORE_LF;
        cfg_data <= {4'd0, cr};
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_register(ufxf_pkg::CFG_FLOW_ENABLE, {4'd0, en});
        sb.set_register(ufxf_pkg::CFG_FLOW_MARGIN, m);
        sb.set_register(ufxf_pkg::CFG_CR_BEFORE_LF, {4'd0, cr});
    endtask

    function automatic logic [2:0] pick_kind(traffic_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL_RX:
                return roll < 80 ? ufxf_pkg::KIND_LINE_RX : roll < 88 ? ufxf_pkg::KIND_READ :
                       roll < 94 ? ufxf_pkg::KIND_TX_READY : 3'($urandom_range(0, 7));
            MIX_DRAIN_RX:
                return roll < 80 ? ufxf_pkg::KIND_READ : roll < 88 ? ufxf_pkg::KIND_LINE_RX :
                       roll < 94 ? ufxf_pkg::KIND_TX_READY : 3'($urandom_range(0, 7));
            MIX_FILL_TX:
                return roll < 80 ? ufxf_pkg::KIND_WRITE :
                       roll < 90 ? ufxf_pkg::KIND_TX_READY : 3'($urandom_range(0, 7));
            MIX_DRAIN_TX:
                return roll < 70 ? ufxf_pkg::KIND_TX_READY :
                       roll < 80 ? ufxf_pkg::KIND_WRITE : 3'($urandom_range(0, 7));
            default:
                return roll < 90 ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        endcase
    endfunction

    task automatic run_traffic(input traffic_t mix, input int count);
        logic [2:0] kind;
        logic [7:0] data;
        for (int n = 0; n < count; n++)
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
                sender_pause($urandom_range(1, 14));
            kind = pick_kind(mix);
            data = 8'($urandom_range(0, 255));
            // favor line feeds so CR insertion and the two-place check get exercised
            if (kind == ufxf_pkg::KIND_WRITE && $urandom_range(0, 3) == 0)
                data = ufxf_pkg::CH_LF;
            send_event(kind, data);
        end
    endtask

    task automatic run_phase(input bit en, input logic [4:0] m, input bit cr,
                             input traffic_t mix, input int count);
        wait_drained();
        apply_settings(en, m, cr);
        run_traffic(mix, count);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_write <= 1'b0;
        cfg_index <= ufxf_pkg::CFG_FLOW_ENABLE;
        cfg_data <= '0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty read, idle transmitter, byte extremes
        send_event(ufxf_pkg::KIND_READ, 8'hFF);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_LINE_RX, 8'h00);
        send_event(ufxf_pkg::KIND_LINE_RX, 8'hFF);
        send_event(ufxf_pkg::KIND_READ, 8'h00);
        send_event(ufxf_pkg::KIND_READ, 8'h00);
        send_event(ufxf_pkg::KIND_WRITE, 8'h00);
        send_event(ufxf_pkg::KIND_WRITE, 8'hFF);
        send_event(ufxf_pkg::KIND_WRITE, ufxf_pkg::CH_LF);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        // Host flow override: same state is a no-op, a new control replaces a pending one
        send_event(ufxf_pkg::KIND_SET_FLOW, 8'h00);
        send_event(ufxf_pkg::KIND_SET_FLOW, 8'hFE);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_SET_FLOW, 8'h01);
        send_event(ufxf_pkg::KIND_SET_FLOW, 8'h00);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_SET_FLOW, 8'hFF);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(3'd5, 8'hFF);
        send_event(3'd6, 8'h00);
        send_event(3'd7, 8'hFF);
        wait_drained();
        apply_settings(1'b1, ufxf_pkg::MARGIN_RESET, 1'b1);
        send_event(ufxf_pkg::KIND_WRITE, ufxf_pkg::CH_LF);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);
        send_event(ufxf_pkg::KIND_TX_READY, 8'h00);

        run_phase(1'b1, 5'd5, 1'b0, MIX_FILL_RX, 100);
        run_phase(1'b1, 5'd5, 1'b0, MIX_DRAIN_RX, 100);
        wait_drained();
        apply_settings(1'b1, 5'd31, 1'b1);
        hold_request = 1'b1;
        run_traffic(MIX_FILL_TX, 100);
        run_phase(1'b1, 5'd31, 1'b1, MIX_FILL_RX, 100);
        run_phase(1'b1, 5'd31, 1'b1, MIX_DRAIN_TX, 100);
        run_phase(1'b0, 5'd1, 1'b0, MIX_DRAIN_RX, 100);
        run_phase(1'b0, 5'd1, 1'b0, MIX_FILL_RX, 100);
        run_phase(1'b1, 5'd0, 1'b1, MIX_ANY, 100);
        run_phase(1'b1, 5'd0, 1'b1, MIX_DRAIN_RX, 100);
        run_phase(1'b1, 5'd1, 1'b1, MIX_FILL_RX, 100);
        idle_on = 1'b0;
        run_phase(1'b1, 5'd1, 1'b0, MIX_ANY, 150);
        idle_on = 1'b1;
        run_phase(1'b0, 5'd31, 1'b1, MIX_FILL_TX, 100);
        run_phase(1'b1, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), MIX_ANY, 200);
        // closing stretch runs at full rate on both sides
        idle_on = 1'b0;
        run_phase(1'b1, 5'd5, 1'b0, MIX_ANY, 200);

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
